// ----- rtl/lie_pkg.sv -----
// Lagrange interpolation evaluator: shared types, constants and helpers.
// Used by the controller, datapath and top level. No dependencies.
package lie_pkg;

  localparam int MaxNodes   = 8;
  localparam int IdxW       = 3;
  localparam int ValW       = 32;
  localparam int FracW      = 24;
  localparam int WideW      = 64;
  localparam int CntW       = 4;
  localparam logic [CntW-1:0] NodeCountReset = 4'd4;
  localparam logic [62:0] WideMax = 63'h3FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] StatOk  = 2'd0;
  localparam logic [1:0] StatDup = 2'd1;
  localparam logic [1:0] StatSat = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [IdxW-1:0]   node_index;
    logic signed [ValW-1:0] node_x;
    logic signed [ValW-1:0] node_y;
    logic signed [ValW-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] interp_value;
    logic [1:0]             status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic            load;      // write node slot
    logic            q_start;   // latch query, clear sum and flags
    logic            rd_x;      // register x[i], x[j]
    logic            dup_cmp;   // compare registered x[i], x[j]
    logic            p_init;    // p = 1.0
    logic            div_go;    // start divider on registered operands
    logic            div_step;  // one divider iteration
    logic            mul_go;    // latch multiplier operands
    logic            mul_ysel;  // second operand is y instead of ratio
    logic            mul_step;  // one partial product
    logic            mul_r;     // p = p * ratio
    logic            mul_y;     // t = y * p
    logic            acc;       // sum += t
    logic            fin;       // form result
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic dup;
    logic div_done;
    logic mul_done;
  } sts_t;

endpackage

// ----- rtl/lagrange_interpolation_eval_core.sv -----
// Lagrange interpolation evaluator, top level.
// Load: busy stays low, no result. Query of n nodes: each ratio is 57 divider
// steps plus 4 partial-product steps; a duplicate ends early.
// Result strobes for one cycle in the first cycle busy is low; cannot stall.
// Sync active-high reset: idle, node_count = 4; node store is not cleared.
module lagrange_interpolation_eval_core import lie_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  input  logic      cfg_we,
  input  logic [CntW-1:0] cfg_wdata,
  output logic      result_valid,
  output out_item_t result
);

  logic [CntW-1:0] node_count;
  ctl_t ctl;
  sts_t sts;
  logic done;

  // node_count register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) node_count <= NodeCountReset;
    else if (cfg_we) node_count <= cfg_wdata;
  end

  lie_ctrl u_ctrl (
    .clk, .rst, .start(start && !busy), .mode(in_item.mode),
    .node_count, .sts, .ctl, .busy, .done
  );

  lie_dpath u_dpath (
    .clk, .rst, .item(in_item), .ctl, .sts, .res(result)
  );

  // result register loads on the same edge as done
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= done;
  end

endmodule

// ----- rtl/lie_ctrl.sv -----
// Lagrange evaluator controller: sequences duplicate scan and term loops.
// Depends on lie_pkg.
module lie_ctrl import lie_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            mode,
  input  logic [CntW-1:0] node_count,
  input  sts_t            sts,
  output ctl_t            ctl,
  output logic            busy,
  output logic            done
);

  localparam logic [3:0] S_IDLE = 4'd0, S_DRD = 4'd1, S_DCMP = 4'd2, S_PINI = 4'd3,
                         S_XRD = 4'd4, S_DGO = 4'd5, S_DIV = 4'd6, S_MR = 4'd7,
                         S_YRD = 4'd8, S_MY = 4'd9, S_ACC = 4'd10, S_FIN = 4'd11,
                         S_DUP = 4'd12, S_YW = 4'd13;

  logic [3:0] state, state_next;
  logic [IdxW-1:0] i, j, i_next, j_next;
  logic [IdxW-1:0] last, last_next;
  logic [CntW-1:0] nc;

  always_comb begin
    if (node_count == '0) nc = CntW'(1);
    else if (node_count > CntW'(MaxNodes)) nc = CntW'(MaxNodes);
    else nc = node_count;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    i_next = i;
    j_next = j;
    last_next = last;
    ctl = '0;
    ctl.i = i;
    ctl.j = j;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (!mode) ctl.load = 1'b1;
          else begin
            ctl.q_start = 1'b1;
            last_next = IdxW'(nc - CntW'(1));
            i_next = '0;
            j_next = IdxW'(1);
            state_next = (nc == CntW'(1)) ? S_PINI : S_DRD;
            if (nc == CntW'(1)) j_next = '0;
          end
        end
      end
      S_DRD: begin
        ctl.rd_x = 1'b1;
        state_next = S_DCMP;
      end
      S_DCMP: begin
        ctl.dup_cmp = 1'b1;
        state_next = S_DUP;
      end
      S_DUP: begin
        if (sts.dup) begin
          ctl.fin = 1'b1;
          done = 1'b1;
          state_next = S_IDLE;
        end else if (j == last) begin
          if (i + IdxW'(1) == last) begin
            i_next = '0;
            j_next = '0;
            state_next = S_PINI;
          end else begin
            i_next = i + IdxW'(1);
            j_next = i + IdxW'(2);
            state_next = S_DRD;
          end
        end else begin
          j_next = j + IdxW'(1);
          state_next = S_DRD;
        end
      end
      S_PINI: begin
        ctl.p_init = 1'b1;
        j_next = '0;
        state_next = (i == '0 && last == '0) ? S_YRD : S_XRD;
        if (i == '0 && last != '0) j_next = IdxW'(1);
        if (i != '0) j_next = '0;
      end
      S_XRD: begin
        ctl.rd_x = 1'b1;
        state_next = S_DGO;
      end
      S_DGO: begin
        ctl.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          ctl.mul_go = 1'b1;
          state_next = S_MR;
        end
      end
      S_MR: begin
        ctl.mul_step = 1'b1;
        if (sts.mul_done) begin
          ctl.mul_r = 1'b1;
          // next j skipping i
          if (j == last || (j + IdxW'(1) == i && i == last)) state_next = S_YRD;
          else begin
            j_next = (j + IdxW'(1) == i) ? j + IdxW'(2) : j + IdxW'(1);
            state_next = S_XRD;
          end
        end
      end
      S_YRD: begin
        ctl.rd_x = 1'b1;
        state_next = S_MY;
      end
      S_MY: begin
        ctl.mul_go = 1'b1;
        ctl.mul_ysel = 1'b1;
        state_next = S_YW;
      end
      S_YW: begin
        ctl.mul_step = 1'b1;
        if (sts.mul_done) begin
          ctl.mul_y = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        ctl.acc = 1'b1;
        if (i == last) state_next = S_FIN;
        else begin
          i_next = i + IdxW'(1);
          state_next = S_PINI;
        end
      end
      S_FIN: begin
        ctl.fin = 1'b1;
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0;
      j <= '0;
      last <= '0;
    end else begin
      state <= state_next;
      i <= i_next;
      j <= j_next;
      last <= last_next;
    end
  end

endmodule

// ----- rtl/lie_dpath.sv -----
// Lagrange evaluator datapath: node store, restoring divider, split Q24 multiplier.
// Depends on lie_pkg.
module lie_dpath import lie_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  item,
  input  ctl_t      ctl,
  output sts_t      sts,
  output out_item_t res
);

  logic signed [ValW-1:0] xs [MaxNodes];
  logic signed [ValW-1:0] ys [MaxNodes];
  logic signed [ValW-1:0] q, xi, xj, yi;
  logic dup, sat;

  // divider
  logic [ValW:0] dn, dd;         // magnitudes (33 bit)
  logic [ValW+FracW:0] quo;      // 57-bit quotient
  logic [ValW+1:0] rem;
  logic [6:0] cnt;
  logic dneg;
  logic signed [ValW:0] numd, dend;
  logic [ValW+1:0] rsh;

  // multiply
  logic signed [WideW-1:0] p, t, sum;
  logic [62:0] pmag;
  logic [62:0] mop;
  logic [62:0] ma, mb;           // latched magnitudes
  logic [125:0] macc;            // full product, built from four 32x32 parts
  logic [2:0] mcnt;
  logic [31:0] ma_h, mb_h;
  logic [63:0] pp;
  logic [125:0] pp_sh;
  logic [62:0] mres;
  logic msat;

  localparam int DivSteps = ValW + 1 + FracW;
  localparam int MulSteps = 4;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      xs[item.node_index] <= item.node_x;
      ys[item.node_index] <= item.node_y;
    end
  end

  assign numd = {q[ValW-1], q} - {xj[ValW-1], xj};
  assign dend = {xi[ValW-1], xi} - {xj[ValW-1], xj};
  assign rsh = {rem[ValW:0], dn[ValW]};

  // one partial product a cycle: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    ma_h = mcnt[1] ? {1'b0, ma[62:32]} : ma[31:0];
    mb_h = mcnt[0] ? {1'b0, mb[62:32]} : mb[31:0];
    pp = 64'(ma_h) * 64'(mb_h);
    pp_sh = 126'(pp) << {mcnt[1] & mcnt[0], mcnt[1] ^ mcnt[0], 5'd0};
  end

  // scale the finished product back to Q24 and check the wide bound
  always_comb begin
    if (macc[125:FracW+63] != '0) begin
      mres = WideMax;
      msat = 1'b1;
    end else begin
      mres = macc[FracW+62:FracW];
      msat = (mres > WideMax);
    end
  end

  function automatic logic [62:0] abs63(input logic signed [WideW-1:0] v);
    logic [WideW-1:0] m;
    m = v[WideW-1] ? -v : v;
    return m[62:0];
  endfunction

  // quotient is below 2^57, so it never reaches the wide bound
  always_comb begin
    pmag = abs63(p);
    mop = ctl.mul_ysel ? 63'(yi[ValW-1] ? -{{31{yi[ValW-1]}}, yi} : {31'd0, yi})
                       : 63'(quo);
  end

  logic signed [WideW:0] s65;
  assign s65 = {sum[WideW-1], sum} + {t[WideW-1], t};

  always_ff @(posedge clk) begin
    if (ctl.q_start) begin
      q <= item.query_x;
      dup <= 1'b0;
      sat <= 1'b0;
      sum <= '0;
    end
    if (ctl.rd_x) begin
      xi <= xs[ctl.i];
      xj <= xs[ctl.j];
      yi <= ys[ctl.i];
    end
    if (ctl.dup_cmp) dup <= (xi == xj);
    if (ctl.p_init) p <= WideW'(1) <<< FracW;
    if (ctl.div_go) begin
      dn <= numd[ValW] ? -numd : numd;
      dd <= dend[ValW] ? -dend : dend;
      dneg <= numd[ValW] ^ dend[ValW];
      rem <= '0;
      quo <= '0;
      cnt <= '0;
    end else if (ctl.div_step && cnt != 7'(DivSteps)) begin
      // restoring division of dn*2^24 by dd, one bit a cycle
      if (rsh >= {1'b0, dd}) begin
        rem <= rsh - {1'b0, dd};
        quo <= {quo[ValW+FracW-1:0], 1'b1};
      end else begin
        rem <= rsh;
        quo <= {quo[ValW+FracW-1:0], 1'b0};
      end
      dn <= {dn[ValW-1:0], 1'b0};
      cnt <= cnt + 7'd1;
    end
    if (ctl.mul_go) begin
      ma <= pmag;
      mb <= mop;
      macc <= '0;
      mcnt <= '0;
    end else if (ctl.mul_step && mcnt != 3'(MulSteps)) begin
      macc <= macc + pp_sh;
      mcnt <= mcnt + 3'd1;
    end
    if (ctl.mul_r) begin
      p <= (p[WideW-1] ^ dneg) ? -$signed({1'b0, mres}) : $signed({1'b0, mres});
      if (msat) sat <= 1'b1;
    end
    if (ctl.mul_y) begin
      t <= (p[WideW-1] ^ yi[ValW-1]) ? -$signed({1'b0, mres}) : $signed({1'b0, mres});
      if (msat) sat <= 1'b1;
    end
    if (ctl.acc) begin
      if (s65 > 65'sh0_3FFF_FFFF_FFFF_FFFF) begin
        sum <= $signed({1'b0, WideMax});
        sat <= 1'b1;
      end else if (s65 < -65'sh0_3FFF_FFFF_FFFF_FFFF) begin
        sum <= -$signed({1'b0, WideMax});
        sat <= 1'b1;
      end else sum <= s65[WideW-1:0];
    end
  end

  assign sts.dup = dup;
  assign sts.div_done = (cnt == 7'(DivSteps));
  assign sts.mul_done = (mcnt == 3'(MulSteps));

  logic signed [ValW-1:0] fv;
  logic fsat;
  always_comb begin
    fsat = 1'b0;
    fv = sum[ValW-1:0];
    if (sum > WideW'(32'sh7FFF_FFFF)) begin
      fv = 32'sh7FFF_FFFF;
      fsat = 1'b1;
    end else if (sum < -WideW'(64'sh8000_0000)) begin
      fv = 32'sh8000_0000;
      fsat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (ctl.fin) begin
      if (dup) begin
        res.interp_value <= '0;
        res.status <= StatDup;
      end else begin
        res.interp_value <= fv;
        res.status <= (sat || fsat) ? StatSat : StatOk;
      end
    end
  end

endmodule
